/* rtl/bdq_pkg.sv */
package bdq_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic    cap_item;
        logic    scan_start;
        logic    scan_adv;
        logic    wr_front;
        logic    wr_back;
        logic    pop_front;
        logic    pop_back;
        logic    load_out;
        status_t out_status;
        logic    out_data;
        logic    out_pos;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic match;
        logic last;
        logic out_free;
    } ctl_stat_t;

endpackage

/* rtl/bdq_req_if.sv */
interface bdq_req_if import bdq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

/* rtl/bdq_rsp_if.sv */
interface bdq_rsp_if import bdq_pkg::*; #(
    parameter int POS_W = 4,
    parameter int OCC_W = 5
) ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] data_out;
    logic [POS_W-1:0]          position;
    logic [OCC_W-1:0]          occupancy;

    modport source (output valid, output status, output data_out, output position,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input data_out, input position,
                    input occupancy, output ready);
endinterface

/* rtl/bounded_deque_with_search.sv */
// Path from accepted command to result: push and unused codes load the result in
// the execute state; pop reads the RAM there and loads it in the read state; a
// search ends at a match or after the last held element (empty ring: not found
// from the execute state). The ring RAM has one read port, so a search scans one
// slot per cycle; a new command is taken the cycle after the result is registered.
// Reset clears front index, count and output valid; the RAM is not cleared.
module bounded_deque_with_search import bdq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ctl_cmd_t  ctl;
    ctl_stat_t stat;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    bdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_cmd       (req.cmd),
        .req_value     (req.value),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .rsp_status    (rsp.status),
        .rsp_data_out  (rsp.data_out),
        .rsp_position  (rsp.position),
        .rsp_occupancy (rsp.occupancy),
        .ctl           (ctl),
        .stat          (stat)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("command taken while another is in progress");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.occupancy <= FULL_CNT))
        else $error("occupancy beyond ring depth");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> (rsp.occupancy == FULL_CNT))
        else $error("full refusal on a ring that is not full");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0))
        else $error("empty refusal on a ring that holds elements");

    a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.position != '0) |-> (rsp.status == ST_OK))
        else $error("match position reported without a match");

endmodule

/* rtl/bdq_ctrl.sv */
module bdq_ctrl import bdq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  ctl
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_SCAN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        ctl        = '0;
        ctl.out_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.cap_item = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.op)
                    OP_PUSH_FRONT, OP_PUSH_BACK:
                    begin
                        if (stat.out_free)
                        begin
                            ctl.load_out = 1'b1;
                            if (stat.full)
                            begin
                                ctl.out_status = ST_FULL;
                            end
                            else
                            begin
                                ctl.wr_front = (stat.op == OP_PUSH_FRONT);
                                ctl.wr_back  = (stat.op == OP_PUSH_BACK);
                            end
                            state_next = S_IDLE;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK:
                    begin
                        if (!stat.empty)
                        begin
                            state_next = S_READ;
                        end
                        else if (stat.out_free)
                        begin
                            ctl.load_out   = 1'b1;
                            ctl.out_status = ST_EMPTY;
                            state_next     = S_IDLE;
                        end
                    end
                    OP_SEARCH:
                    begin
                        if (!stat.empty)
                        begin
                            ctl.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        else if (stat.out_free)
                        begin
                            ctl.load_out   = 1'b1;
                            ctl.out_status = ST_NOTFOUND;
                            state_next     = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // unused code: plain ok result, nothing changes
                        if (stat.out_free)
                        begin
                            ctl.load_out = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    ctl.load_out  = 1'b1;
                    ctl.out_data  = 1'b1;
                    ctl.pop_front = (stat.op == OP_POP_FRONT);
                    ctl.pop_back  = (stat.op == OP_POP_BACK);
                    state_next    = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    if (stat.out_free)
                    begin
                        ctl.load_out = 1'b1;
                        ctl.out_data = 1'b1;
                        ctl.out_pos  = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (stat.last)
                begin
                    if (stat.out_free)
                    begin
                        ctl.load_out   = 1'b1;
                        ctl.out_status = ST_NOTFOUND;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    ctl.scan_adv = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/bdq_datapath.sv */
module bdq_datapath import bdq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 4,
    parameter int CW         = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [CMD_W-1:0]          req_cmd,
    input  logic signed [VALUE_W-1:0] req_value,
    input  logic                      rsp_ready,
    output logic                      rsp_valid,
    output logic [STATUS_W-1:0]       rsp_status,
    output logic signed [VALUE_W-1:0] rsp_data_out,
    output logic [AW-1:0]             rsp_position,
    output logic [CW-1:0]             rsp_occupancy,
    input  ctl_cmd_t                  ctl,
    output ctl_stat_t                 stat
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_S  = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [AW-1:0]         front_reg;
    logic [AW-1:0]         front_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [AW-1:0]         idx_reg;
    logic [AW-1:0]         idx_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    status_t                   status_reg;
    logic signed [VALUE_W-1:0] data_reg;
    logic [AW-1:0]             pos_reg;
    logic [CW-1:0]             occ_reg;

    logic signed [63:0]           val_ext;
    logic signed [DATA_WIDTH-1:0] rd_s;
    logic signed [63:0]           rd_ext;
    logic [AW-1:0]                front_dec;
    logic [AW-1:0]                front_inc;
    logic [CW-1:0]                cnt_m1;
    logic [AW-1:0]                rd_off;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                back_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;

    assign val_ext   = 64'(req_value);
    assign rd_s      = rd_data_reg;
    assign rd_ext    = 64'(rd_s);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign cnt_m1    = count_reg - 1'b1;
    assign back_addr = ring_add(front_reg, count_reg[AW-1:0]);

    // for a search, the read address tracks the index that will sit in idx_reg next cycle
    always_comb
    begin
        if (ctl.scan_start)
        begin
            idx_next = '0;
        end
        else if (ctl.scan_adv)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end
        case (op_reg)
            OP_SEARCH:   rd_off = idx_next;
            OP_POP_BACK: rd_off = cnt_m1[AW-1:0];
            default:     rd_off = '0;
        endcase
        rd_addr = ring_add(front_reg, rd_off);
    end

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = front_dec;
        if (ctl.wr_front)
        begin
            wr_en      = 1'b1;
            wr_addr    = front_dec;
            front_next = front_dec;
            count_next = count_reg + 1'b1;
        end
        else if (ctl.wr_back)
        begin
            wr_en      = 1'b1;
            wr_addr    = back_addr;
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop_front)
        begin
            front_next = front_inc;
            count_next = cnt_m1;
        end
        else if (ctl.pop_back)
        begin
            count_next = cnt_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= val_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (ctl.cap_item)
        begin
            op_reg  <= op_t'(req_cmd);
            val_reg <= val_ext[DATA_WIDTH-1:0];
        end
        if (ctl.load_out)
        begin
            status_reg <= ctl.out_status;
            data_reg   <= ctl.out_data ? rd_ext[VALUE_W-1:0] : '0;
            pos_reg    <= ctl.out_pos ? idx_reg : '0;
            occ_reg    <= count_next;
        end
    end

    assign stat.op       = op_reg;
    assign stat.full     = (count_reg == FULL_CNT);
    assign stat.empty    = (count_reg == '0);
    assign stat.match    = (rd_data_reg == val_reg);
    assign stat.last     = ((CW'(idx_reg) + 1'b1) == count_reg);
    assign stat.out_free = !out_valid_reg || rsp_ready;

    assign rsp_valid     = out_valid_reg;
    assign rsp_status    = status_reg;
    assign rsp_data_out  = data_reg;
    assign rsp_position  = pos_reg;
    assign rsp_occupancy = occ_reg;

endmodule
